FILE: design/ftl_pkg.sv
package ftl_pkg;

    localparam int MAX_CELLS = 256;
    localparam int MIN_CELLS = 2;
    localparam int VALUE_W   = 32;

    // node store holds MAX_CELLS+1 entries, current store MAX_CELLS
    localparam int NODE_AW = $clog2(MAX_CELLS + 1);
    localparam int CUR_AW  = $clog2(MAX_CELLS);

    // scaling datapath: operand up to 41 bits signed (resistive load term),
    // coefficient up to 32 bits unsigned, smallest shift 24
    localparam int COEF_W   = 32;
    localparam int OPND_W   = 41;
    localparam int LO_W     = 32;
    localparam int HI_W     = OPND_W - LO_W;
    localparam int PROD_W   = OPND_W + COEF_W;
    localparam int SCALED_W = PROD_W - 24;
    localparam int RAW_W    = SCALED_W + 1;
    localparam int SUM_W    = RAW_W + 1;

    // register file
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int CFG_AW       = 3;
    localparam int COEFF_REG_W  = 31;
    localparam int MODE_W       = 2;
    localparam int RATIO_W      = 32;

    localparam logic [CFG_AW-1:0] REG_V_COEFF      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_I_COEFF      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LOAD_MODE    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_LOAD_RATIO   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OBS_NODE     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ACTIVE_CELLS = 3'd5;

    localparam logic [MODE_W-1:0] LOAD_OPEN  = 2'd1;
    localparam logic [MODE_W-1:0] LOAD_SHORT = 2'd2;

    localparam logic [RATIO_W-1:0] LOAD_RATIO_RST = 32'h0100_0000;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [NODE_AW-1:0]        node_idx_t;

    typedef enum logic [1:0] {
        SH_24,
        SH_30,
        SH_31
    } shift_sel_t;

    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic [COEF_W-1:0]        c;
        shift_sel_t               sh;
        value_t                   base;
        logic                     sub;
    } scale_op_t;

    typedef struct packed {
        logic      to_cur;
        logic      raw;
        node_idx_t addr;
    } scale_tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOLT,
        ST_VDRAIN,
        ST_CURR,
        ST_CDRAIN,
        ST_DONE
    } seq_state_t;

endpackage

FILE: design/ftl_if.sv
interface ftl_src_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ftl_pkg::VALUE_W-1:0]   source_sample;

    modport source (output valid, output source_sample, input ready);
    modport sink   (input valid, input source_sample, output ready);
endinterface

interface ftl_obs_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ftl_pkg::VALUE_W-1:0]   observed_voltage;

    modport source (output valid, output observed_voltage, input ready);
    modport sink   (input valid, input observed_voltage, output ready);
endinterface

FILE: design/ftl_ram.sv
module ftl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/ftl_scale.sv
module ftl_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  ftl_pkg::scale_op_t                in_op,
    input  ftl_pkg::scale_tag_t               in_tag,
    output logic                              out_valid,
    output ftl_pkg::scale_tag_t               out_tag,
    output ftl_pkg::value_t                   out_sat,
    output logic signed [ftl_pkg::RAW_W-1:0]  out_raw,
    output logic                              busy
);
    import ftl_pkg::*;

    // stage 1: sign and magnitude
    logic                s1_valid;
    logic [OPND_W-1:0]   s1_mag;
    logic                s1_neg;
    logic [COEF_W-1:0]   s1_c;
    shift_sel_t          s1_sh;
    value_t              s1_base;
    logic                s1_sub;
    scale_tag_t          s1_tag;

    // stage 2: partial products
    logic                s2_valid;
    logic [2*LO_W-1:0]   s2_plo;
    logic [HI_W+COEF_W-1:0] s2_phi;
    logic                s2_neg;
    shift_sel_t          s2_sh;
    value_t              s2_base;
    logic                s2_sub;
    scale_tag_t          s2_tag;

    // stage 3: rounded magnitude
    logic                s3_valid;
    logic [SCALED_W-1:0] s3_r;
    logic                s3_neg;
    value_t              s3_base;
    logic                s3_sub;
    scale_tag_t          s3_tag;

    logic [OPND_W-1:0]   in_mag;
    logic                in_neg;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   half;
    logic [SCALED_W-1:0] r_next;
    logic signed [SUM_W-1:0] r_ext;
    logic signed [SUM_W-1:0] base_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [RAW_W-1:0] r_signed;
    value_t              sat_next;
    logic signed [RAW_W-1:0] raw_next;

    always_comb
    begin
        in_neg = in_op.a[OPND_W-1];
        in_mag = in_neg ? $unsigned(-in_op.a) : $unsigned(in_op.a);
    end

    always_comb
    begin
        case (s2_sh)
            SH_24:   half = PROD_W'(1) << 23;
            SH_30:   half = PROD_W'(1) << 29;
            default: half = PROD_W'(1) << 30;
        endcase
        prod = {s2_phi, {LO_W{1'b0}}} + PROD_W'(s2_plo) + half;
        case (s2_sh)
            SH_24:   r_next = SCALED_W'(prod >> 24);
            SH_30:   r_next = SCALED_W'(prod >> 30);
            default: r_next = SCALED_W'(prod >> 31);
        endcase
    end

    always_comb
    begin
        r_ext    = signed'({2'b00, s3_r});
        base_ext = SUM_W'(s3_base);
        // sign of the product folded into the add/subtract choice
        if (s3_neg ^ s3_sub)
        begin
            sum = base_ext - r_ext;
        end
        else
        begin
            sum = base_ext + r_ext;
        end
        if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1)
        begin
            sat_next = sum[VALUE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_next = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_next = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        r_signed = signed'({1'b0, s3_r});
        raw_next = s3_neg ? -r_signed : r_signed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid  <= 1'b0;
            s2_valid  <= 1'b0;
            s3_valid  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            s1_valid  <= in_valid;
            s2_valid  <= s1_valid;
            s3_valid  <= s2_valid;
            out_valid <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag  <= in_mag;
        s1_neg  <= in_neg;
        s1_c    <= in_op.c;
        s1_sh   <= in_op.sh;
        s1_base <= in_op.base;
        s1_sub  <= in_op.sub;
        s1_tag  <= in_tag;

        s2_plo  <= s1_mag[LO_W-1:0] * s1_c;
        s2_phi  <= s1_mag[OPND_W-1:LO_W] * s1_c;
        s2_neg  <= s1_neg;
        s2_sh   <= s1_sh;
        s2_base <= s1_base;
        s2_sub  <= s1_sub;
        s2_tag  <= s1_tag;

        s3_r    <= r_next;
        s3_neg  <= s2_neg;
        s3_base <= s2_base;
        s3_sub  <= s2_sub;
        s3_tag  <= s2_tag;

        out_sat <= sat_next;
        out_raw <= raw_next;
        out_tag <= s3_tag;
    end

    assign busy = s1_valid | s2_valid | s3_valid | out_valid;

endmodule

FILE: design/fdtd_transmission_line_step.sv
// One leapfrog step of a lossless 1D transmission line per input beat. Node voltages
// and scaled currents live in two single-port-read memories (257 and 256 words);
// after reset a clearing pass writes zeros to them, during which no input beat is
// taken (register writes are taken as usual). A tick sweeps the node memory once
// for the voltage update (interior, matched source, load) and once more for the
// current update, each sweep reading one word per cycle into a shared scaling
// pipeline and draining it before the next sweep. The memory read port and the
// shared pipeline set the tick length, which grows with the active cell count and
// with a resistive load. The result beat sits in an output register, so the next
// source beat can be taken while it waits.
module fdtd_transmission_line_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ftl_pkg::PADDR_W-1:0]   paddr,
    input  logic [ftl_pkg::PDATA_W-1:0]   pwdata,
    output logic [ftl_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    ftl_src_if.sink                       src_chan,
    ftl_obs_if.source                     obs_chan
);
    import ftl_pkg::*;

    // registers
    logic [COEFF_REG_W-1:0] v_coeff_reg;
    logic [COEFF_REG_W-1:0] i_coeff_reg;
    logic [MODE_W-1:0]      load_mode_reg;
    logic [RATIO_W-1:0]     load_ratio_reg;
    node_idx_t              obs_node_reg;
    node_idx_t              active_cells_reg;
    logic                   cfg_write;
    logic [CFG_AW-1:0]      cfg_sel;

    // sequencer
    seq_state_t  state_reg;
    seq_state_t  state_next;
    node_idx_t   cnt_reg;
    node_idx_t   cnt_next;
    logic        rd_issue;
    logic        rd_issue_curr;
    logic        out_load;
    logic        accept;
    logic        drained;
    node_idx_t   n_eff;
    node_idx_t   obs_eff;

    // per-tick copies
    node_idx_t         n_reg;
    node_idx_t         obs_reg;
    logic [MODE_W-1:0] mode_reg;
    value_t            vs_reg;

    // read stream
    logic        rd_valid_reg;
    logic        rd_curr_reg;
    node_idx_t   rd_idx_reg;
    value_t      i_prev_reg;
    value_t      v_prev_reg;
    value_t      i_load_reg;
    value_t      v_load_reg;
    value_t      obs_val_reg;

    // operand register into the scaling pipeline
    logic        op_valid_reg;
    logic        op_valid_next;
    scale_op_t   op_reg;
    scale_op_t   op_next;
    scale_tag_t  op_tag_reg;
    scale_tag_t  op_tag_next;
    logic signed [RAW_W-1:0] load_diff;

    logic                    res_valid;
    scale_tag_t              res_tag;
    value_t                  res_sat;
    logic signed [RAW_W-1:0] res_raw;
    logic                    sc_busy;

    logic        out_valid_reg;
    value_t      out_data_reg;

    // memories
    logic              v_we;
    node_idx_t         v_waddr;
    value_t            v_wdata;
    value_t            v_rdata;
    logic              i_we;
    logic [CUR_AW-1:0] i_waddr;
    value_t            i_wdata;
    value_t            i_rdata;

    ftl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_CELLS + 1)) u_node_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (cnt_reg),
        .rdata (v_rdata)
    );

    ftl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_CELLS)) u_cur_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (cnt_reg[CUR_AW-1:0]),
        .rdata (i_rdata)
    );

    ftl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_valid_reg),
        .in_op     (op_reg),
        .in_tag    (op_tag_reg),
        .out_valid (res_valid),
        .out_tag   (res_tag),
        .out_sat   (res_sat),
        .out_raw   (res_raw),
        .busy      (sc_busy)
    );

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_coeff_reg      <= '0;
            i_coeff_reg      <= '0;
            load_mode_reg    <= '0;
            load_ratio_reg   <= LOAD_RATIO_RST;
            obs_node_reg     <= '0;
            active_cells_reg <= NODE_AW'(MAX_CELLS);
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_V_COEFF:      v_coeff_reg      <= pwdata[COEFF_REG_W-1:0];
                REG_I_COEFF:      i_coeff_reg      <= pwdata[COEFF_REG_W-1:0];
                REG_LOAD_MODE:    load_mode_reg    <= pwdata[MODE_W-1:0];
                REG_LOAD_RATIO:   load_ratio_reg   <= pwdata[RATIO_W-1:0];
                REG_OBS_NODE:     obs_node_reg     <= pwdata[NODE_AW-1:0];
                REG_ACTIVE_CELLS: active_cells_reg <= pwdata[NODE_AW-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_V_COEFF:      prdata = PDATA_W'(v_coeff_reg);
            REG_I_COEFF:      prdata = PDATA_W'(i_coeff_reg);
            REG_LOAD_MODE:    prdata = PDATA_W'(load_mode_reg);
            REG_LOAD_RATIO:   prdata = PDATA_W'(load_ratio_reg);
            REG_OBS_NODE:     prdata = PDATA_W'(obs_node_reg);
            REG_ACTIVE_CELLS: prdata = PDATA_W'(active_cells_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        if (active_cells_reg < NODE_AW'(MIN_CELLS))
        begin
            n_eff = NODE_AW'(MIN_CELLS);
        end
        else if (active_cells_reg > NODE_AW'(MAX_CELLS))
        begin
            n_eff = NODE_AW'(MAX_CELLS);
        end
        else
        begin
            n_eff = active_cells_reg;
        end
        obs_eff = (obs_node_reg > n_eff) ? n_eff : obs_node_reg;
    end

    assign src_chan.ready = (state_reg == ST_IDLE);
    assign accept         = src_chan.valid && src_chan.ready;
    assign drained        = !rd_valid_reg && !op_valid_reg && !sc_busy;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_issue      = 1'b0;
        rd_issue_curr = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == NODE_AW'(MAX_CELLS))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (src_chan.valid)
                begin
                    state_next = ST_VOLT;
                    cnt_next   = '0;
                end
            end
            ST_VOLT:
            begin
                rd_issue = 1'b1;
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_VDRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_VDRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_CURR;
                    cnt_next   = '0;
                end
            end
            ST_CURR:
            begin
                rd_issue      = 1'b1;
                rd_issue_curr = 1'b1;
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_CDRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CDRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || obs_chan.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_issue;
            op_valid_reg <= op_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (obs_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- operand build ----------------
    always_comb
    begin
        op_valid_next = 1'b0;
        op_next       = op_reg;
        op_tag_next   = op_tag_reg;
        load_diff     = RAW_W'(i_load_reg) - res_raw;
        if (rd_valid_reg)
        begin
            if (!rd_curr_reg)
            begin
                op_valid_next = 1'b1;
                op_next.c     = COEF_W'(v_coeff_reg);
                op_next.sub   = 1'b0;
                op_next.base  = v_rdata;
                op_tag_next   = '{to_cur: 1'b0, raw: 1'b0, addr: rd_idx_reg};
                if (rd_idx_reg == '0)
                begin
                    // matched source node
                    op_next.a  = OPND_W'(vs_reg) - OPND_W'(v_rdata) - OPND_W'(i_rdata);
                    op_next.sh = SH_30;
                end
                else if (rd_idx_reg == n_reg)
                begin
                    if (mode_reg == LOAD_SHORT)
                    begin
                        op_next.a    = '0;
                        op_next.base = '0;
                        op_next.sh   = SH_30;
                    end
                    else if (mode_reg == LOAD_OPEN)
                    begin
                        op_next.a  = OPND_W'(i_prev_reg);
                        op_next.sh = SH_30;
                    end
                    else
                    begin
                        // resistive: V*ratio first, result loops back below
                        op_next.a       = OPND_W'(v_rdata);
                        op_next.c       = COEF_W'(load_ratio_reg);
                        op_next.sh      = SH_24;
                        op_tag_next.raw = 1'b1;
                    end
                end
                else
                begin
                    op_next.a   = OPND_W'(i_rdata) - OPND_W'(i_prev_reg);
                    op_next.sh  = SH_31;
                    op_next.sub = 1'b1;
                end
            end
            else if (rd_idx_reg != '0)
            begin
                op_valid_next = 1'b1;
                op_next.a     = OPND_W'(v_rdata) - OPND_W'(v_prev_reg);
                op_next.c     = COEF_W'(i_coeff_reg);
                op_next.sh    = SH_31;
                op_next.sub   = 1'b1;
                op_next.base  = i_prev_reg;
                op_tag_next   = '{to_cur: 1'b1, raw: 1'b0, addr: rd_idx_reg - 1'b1};
            end
        end
        else if (res_valid && res_tag.raw)
        begin
            op_valid_next = 1'b1;
            op_next.a     = OPND_W'(load_diff);
            op_next.c     = COEF_W'(v_coeff_reg);
            op_next.sh    = SH_30;
            op_next.sub   = 1'b0;
            op_next.base  = v_load_reg;
            op_tag_next   = '{to_cur: 1'b0, raw: 1'b0, addr: n_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        op_tag_reg  <= op_tag_next;
        rd_idx_reg  <= cnt_reg;
        rd_curr_reg <= rd_issue_curr;
        if (accept)
        begin
            vs_reg   <= src_chan.source_sample;
            n_reg    <= n_eff;
            obs_reg  <= obs_eff;
            mode_reg <= load_mode_reg;
        end
        if (rd_valid_reg)
        begin
            i_prev_reg <= i_rdata;
            v_prev_reg <= v_rdata;
            if (!rd_curr_reg && rd_idx_reg == n_reg)
            begin
                v_load_reg <= v_rdata;
                i_load_reg <= i_prev_reg;
            end
            if (rd_curr_reg && rd_idx_reg == obs_reg)
            begin
                obs_val_reg <= v_rdata;
            end
        end
        if (out_load)
        begin
            out_data_reg <= obs_val_reg;
        end
    end

    // ---------------- write-back ----------------
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            v_we    = 1'b1;
            v_waddr = cnt_reg;
            v_wdata = '0;
            i_we    = (cnt_reg < NODE_AW'(MAX_CELLS));
            i_waddr = cnt_reg[CUR_AW-1:0];
            i_wdata = '0;
        end
        else
        begin
            v_we    = res_valid && !res_tag.raw && !res_tag.to_cur;
            v_waddr = res_tag.addr;
            v_wdata = res_sat;
            i_we    = res_valid && !res_tag.raw && res_tag.to_cur;
            i_waddr = res_tag.addr[CUR_AW-1:0];
            i_wdata = res_sat;
        end
    end

    assign obs_chan.valid            = out_valid_reg;
    assign obs_chan.observed_voltage = out_data_reg;

    // ---------------- checks ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> drained)
        else $error("datapath still busy while waiting for a source beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_valid_reg && res_valid && res_tag.raw))
        else $error("load feedback collides with a memory read");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_VOLT) && (cnt_reg == '0))
        else $error("voltage sweep did not start at node zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        i_we |-> (state_reg == ST_CLEAR || state_reg == ST_CURR
                  || state_reg == ST_CDRAIN))
        else $error("current store written outside the current sweep");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ftl_pkg::*;

    localparam longint VOLT_MAX = 64'sd2147483647;
    localparam longint VOLT_MIN = -64'sd2147483648;
    localparam value_t VALUE_HI = 32'sh7FFF_FFFF;
    localparam value_t VALUE_LO = 32'sh8000_0000;

    // two indexes past the last register, decoded by nothing
    localparam logic [CFG_AW-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_7 = 3'd7;

    localparam int RANDOM_BEATS = 1250;
    localparam int TAIL_CYCLES  = 600;
    localparam int REPORT_CAP   = 50;

    typedef enum int {
        WAVE_PULSE,
        WAVE_RAMP,
        WAVE_STEP,
        WAVE_NOISE
    } wave_t;

    typedef struct packed {
        logic                wr;
        logic [CFG_AW-1:0]   idx;
        logic [PDATA_W-1:0]  val;
        logic                beat;
        value_t              sample;
        logic                known;
        value_t              want;
    } step_row_t;

    localparam int DIR_ROWS = 35;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ftl_src_if src_bus ();
    ftl_obs_if obs_bus ();

    fdtd_transmission_line_step i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .src_chan (src_bus),
        .obs_chan (obs_bus)
    );

    // line state and register copies
    value_t              node_v [0:MAX_CELLS];
    value_t              cur_i  [0:MAX_CELLS-1];
    logic [30:0]         vc_reg;
    logic [30:0]         ic_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [8:0]          obs_reg;
    logic [8:0]          cells_reg;

    value_t pending_volts [$];
    int     mismatch_count;
    bit     no_idle;

    // directed table: typed results only where they follow at a glance
    step_row_t dir_rows [0:DIR_ROWS-1] = '{
        // coefficients zero after reset: nothing moves
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h8000_0000, 1'b1, 32'h0},
        // top bit dropped, v_coeff just under one
        '{1'b1, REG_V_COEFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        // below the minimum, runs as two cells
        '{1'b1, REG_ACTIVE_CELLS, 32'h1, 1'b0, 32'h0, 1'b0, 32'h0},
        // source node doubles the drive and clips both ways
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h0, 1'b0, 32'h0},
        '{1'b1, REG_I_COEFF, 32'hC000_0000, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b1, REG_OBS_NODE, 32'h1, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h1000_0000, 1'b0, 32'h0},
        // observation past the load reads the load node
        '{1'b1, REG_OBS_NODE, 32'h12C, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'hF000_0000, 1'b0, 32'h0},
        '{1'b1, REG_LOAD_MODE, 32'(LOAD_OPEN), 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h0800_0000, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h0, 1'b0, 32'h0},
        '{1'b1, REG_LOAD_MODE, 32'(LOAD_SHORT), 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h1234_5678, 1'b1, 32'h0},
        // all ones masks down to the undecoded mode, taken as resistive
        '{1'b1, REG_LOAD_MODE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h2000_0000, 1'b0, 32'h0},
        '{1'b1, REG_LOAD_RATIO, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'hE000_0000, 1'b0, 32'h0},
        '{1'b1, REG_LOAD_RATIO, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h1FFF_FFFF, 1'b0, 32'h0},
        '{1'b1, REG_ACTIVE_CELLS, 32'h4, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{1'b1, REG_SPARE_6, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b1, REG_SPARE_7, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h0000_0001, 1'b0, 32'h0},
        '{1'b1, REG_ACTIVE_CELLS, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h8000_0001, 1'b0, 32'h0},
        // 511 cells clamp to the full line
        '{1'b1, REG_ACTIVE_CELLS, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b1, REG_OBS_NODE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'h4000_0000, 1'b0, 32'h0},
        // shrink again: the far nodes must keep their values
        '{1'b1, REG_ACTIVE_CELLS, 32'h2, 1'b0, 32'h0, 1'b0, 32'h0},
        '{1'b0, REG_V_COEFF, 32'h0, 1'b1, 32'hC000_0000, 1'b0, 32'h0}
    };

    function automatic value_t clamp(input longint x);
        if (x > VOLT_MAX) return VALUE_HI;
        if (x < VOLT_MIN) return VALUE_LO;
        return value_t'(x);
    endfunction

    // a * c / 2^sh, rounded to nearest, ties away from zero
    function automatic longint rnd_scale(input longint a, input logic [31:0] c, input int sh);
        longint       mag;
        logic [127:0] p;
        mag = (a < 0) ? -a : a;
        p = ((128'(mag) * 128'(c)) + (128'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic int eff_cells(input logic [8:0] c);
        if (c < MIN_CELLS) return MIN_CELLS;
        if (c > MAX_CELLS) return MAX_CELLS;
        return int'(c);
    endfunction

    function automatic logic [PDATA_W-1:0] reg_field(input logic [CFG_AW-1:0] idx,
                                                     input logic [PDATA_W-1:0] val);
        case (idx)
            REG_V_COEFF, REG_I_COEFF:    return val & 32'h7FFF_FFFF;
            REG_LOAD_MODE:               return val & 32'h3;
            REG_LOAD_RATIO:              return val;
            REG_OBS_NODE, REG_ACTIVE_CELLS: return val & 32'h1FF;
            default:                     return '0;
        endcase
    endfunction

    function automatic void store_reg(input logic [CFG_AW-1:0] idx,
                                      input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] f;
        f = reg_field(idx, val);
        case (idx)
            REG_V_COEFF:      vc_reg    = f[30:0];
            REG_I_COEFF:      ic_reg    = f[30:0];
            REG_LOAD_MODE:    mode_reg  = f[MODE_W-1:0];
            REG_LOAD_RATIO:   ratio_reg = f;
            REG_OBS_NODE:     obs_reg   = f[8:0];
            REG_ACTIVE_CELLS: cells_reg = f[8:0];
            default:          ;
        endcase
    endfunction

    // one leapfrog step of the line; returns the observed node voltage
    function automatic value_t advance_line(input value_t vs);
        int     n;
        int     i;
        int     obs;
        longint d;
        n = eff_cells(cells_reg);
        for (i = 1; i < n; i++)
        begin
            d = longint'(cur_i[i]) - longint'(cur_i[i-1]);
            node_v[i] = clamp(longint'(node_v[i]) - rnd_scale(d, 32'(vc_reg), 31));
        end
        d = (longint'(vs) - longint'(node_v[0])) - longint'(cur_i[0]);
        node_v[0] = clamp(longint'(node_v[0]) + rnd_scale(d, 32'(vc_reg), 30));
        case (mode_reg)
            LOAD_SHORT: node_v[n] = '0;
            LOAD_OPEN:
                node_v[n] = clamp(longint'(node_v[n])
                                  + rnd_scale(longint'(cur_i[n-1]), 32'(vc_reg), 30));
            default:
            begin
                d = longint'(cur_i[n-1]) - rnd_scale(longint'(node_v[n]), ratio_reg, 24);
                node_v[n] = clamp(longint'(node_v[n]) + rnd_scale(d, 32'(vc_reg), 30));
            end
        endcase
        for (i = 0; i < n; i++)
        begin
            d = longint'(node_v[i+1]) - longint'(node_v[i]);
            cur_i[i] = clamp(longint'(cur_i[i]) - rnd_scale(d, 32'(ic_reg), 31));
        end
        obs = (int'(obs_reg) > n) ? n : int'(obs_reg);
        return node_v[obs];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        logic [PADDR_W-1:0] addr;
        addr = {idx, 2'b00};
        apb_xfer(1'b1, addr, val, rd);
        store_reg(idx, val);
        if (idx <= REG_ACTIVE_CELLS)
        begin
            apb_xfer(1'b0, addr, '0, rd);
            if (rd !== reg_field(idx, val))
                report_mismatch("register readback", rd, reg_field(idx, val));
        end
    endtask

    task automatic send_tick(input value_t sample, input logic known, input value_t want);
        int     gap;
        int     r;
        value_t v;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) gap = 0;
        else if (r < 85)       gap = $urandom_range(1, 3);
        else if (r < 96)       gap = $urandom_range(4, 20);
        else                   gap = $urandom_range(21, 120);
        if (gap > 0)
        begin
            src_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_bus.valid         <= 1'b1;
        src_bus.source_sample <= sample;
        do @(posedge clk); while (src_bus.ready !== 1'b1);
        v = advance_line(sample);
        pending_volts.insert(pending_volts.size(), known ? want : v);
    endtask

    // registers change only with the line idle
    task automatic drain_line();
        src_bus.valid <= 1'b0;
        while (pending_volts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("** fdtd_transmission_line_step: FAILED **");
        $finish;
    end

    // result side: check each beat, random back-pressure
    initial
    begin
        int     ready_left;
        int     r;
        value_t want;
        obs_bus.ready = 1'b0;
        ready_left = 0;
        forever
        begin
            @(posedge clk);
            if (obs_bus.valid === 1'b1 && obs_bus.ready === 1'b1)
            begin
                if (pending_volts.size() == 0)
                begin
                    report_mismatch("beat with nothing pending", obs_bus.observed_voltage, '0);
                end
                else
                begin
                    want = pending_volts.pop_front();
                    if (obs_bus.observed_voltage !== want)
                        report_mismatch("observed_voltage", obs_bus.observed_voltage, want);
                end
            end
            if (no_idle)
            begin
                obs_bus.ready <= 1'b1;
            end
            else if (ready_left > 0)
            begin
                ready_left--;
            end
            else if (obs_bus.ready)
            begin
                r = $urandom_range(0, 99);
                obs_bus.ready <= 1'b0;
                if (r < 70)      ready_left = $urandom_range(1, 3);
                else if (r < 93) ready_left = $urandom_range(4, 20);
                else             ready_left = $urandom_range(21, 150);
            end
            else
            begin
                obs_bus.ready <= 1'b1;
                ready_left = $urandom_range(1, 30);
            end
        end
    end

    initial
    begin
        int          k;
        int          r;
        int          pos;
        int          count;
        int          period;
        int          n_now;
        int          random_beats;
        longint      amp;
        wave_t       shape;
        value_t      smp;
        logic [31:0] junk;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        src_bus.valid         = 1'b0;
        src_bus.source_sample = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        for (k = 0; k <= MAX_CELLS; k++) node_v[k] = '0;
        for (k = 0; k < MAX_CELLS; k++) cur_i[k] = '0;
        vc_reg    = '0;
        ic_reg    = '0;
        mode_reg  = '0;
        ratio_reg = LOAD_RATIO_RST;
        obs_reg   = '0;
        cells_reg = 9'(MAX_CELLS);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_rows[k].wr)
            begin
                drain_line();
                set_reg(dir_rows[k].idx, dir_rows[k].val);
            end
            if (dir_rows[k].beat)
                send_tick(dir_rows[k].sample, dir_rows[k].known, dir_rows[k].want);
        end

        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            drain_line();
            no_idle = ($urandom_range(0, 4) == 0);

            // coefficients: mostly 0.1 .. 0.9, now and then an extreme or junk top bit
            repeat (2)
            begin
                r = $urandom_range(0, 19);
                junk = 32'($urandom_range(0, 1)) << 31;
                if (r == 0)      smp = '0;
                else if (r == 1) smp = VALUE_HI;
                else if (r == 2) smp = value_t'($urandom);
                else
                    smp = value_t'($urandom_range(32'h0CCC_CCCC, 32'h7333_3333) | junk);
                if ($urandom_range(0, 1)) set_reg(REG_V_COEFF, smp);
                else                      set_reg(REG_I_COEFF, smp);
            end
            if ($urandom_range(0, 3) != 0)
                set_reg(REG_LOAD_MODE, 32'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
            begin
                r = $urandom_range(0, 7);
                if (r == 0)      junk = '0;
                else if (r == 1) junk = 32'hFFFF_FFFF;
                else if (r < 4)  junk = $urandom;
                else if (r == 4) junk = LOAD_RATIO_RST;
                else             junk = $urandom_range(0, 32'h0400_0000);
                set_reg(REG_LOAD_RATIO, junk);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                // long lines are slow, so only now and then
                r = $urandom_range(0, 15);
                if (r == 0)      junk = $urandom_range(200, 511);
                else if (r == 1) junk = $urandom_range(0, 1);
                else             junk = $urandom_range(2, 24);
                set_reg(REG_ACTIVE_CELLS, junk);
            end
            n_now = eff_cells(cells_reg);
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 19) < 3) junk = $urandom_range(0, 511);
                else                           junk = $urandom_range(0, n_now + 1);
                set_reg(REG_OBS_NODE, junk);
            end

            count  = (n_now > 64) ? $urandom_range(6, 16) : $urandom_range(30, 70);
            shape  = wave_t'($urandom_range(0, 3));
            period = $urandom_range(10, 40);
            amp    = longint'($urandom_range(0, 32'h1000_0000));
            if ($urandom_range(0, 1)) amp = -amp;

            for (k = 0; k < count; k++)
            begin
                pos = k % period;
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    smp = value_t'($urandom);
                end
                else if (r < 10)
                begin
                    smp = (r == 8) ? VALUE_HI : VALUE_LO;
                end
                else
                begin
                    case (shape)
                        WAVE_PULSE: smp = (pos < 3) ? value_t'(amp) : '0;
                        WAVE_RAMP:  smp = value_t'(amp * pos / period);
                        WAVE_STEP:  smp = value_t'(amp);
                        default:    smp = value_t'($urandom);
                    endcase
                end
                send_tick(smp, 1'b0, '0);
            end
            random_beats += count;
        end

        drain_line();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_volts.size() != 0)
            report_mismatch("results never arrived", pending_volts.size(), '0);
        if (mismatch_count == 0)
            $display("** fdtd_transmission_line_step: PASSED **");
        else
            $display("** fdtd_transmission_line_step: FAILED **");
        $finish;
    end

endmodule
